@@ sv/fra_pkg.sv @@
// Package with the shared types and constants of the fenced ring allocator.
package fra_pkg;

  localparam int UNIT_W   = 32;
  localparam int OFFSET_W = 31;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int ALIGN_W  = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [UNIT_W-1:0] RING_MAX = 32'h8000_0000;
  localparam logic [UNIT_W-1:0] RING_RESET = 32'd65536;
  localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd8;

  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOP   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_ROOM    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_QUEUE_FULL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_LOG2 = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SIZE,
    ST_COMMIT,
    ST_RETIRE,
    ST_FINISH
  } fra_state_t;

  typedef struct packed {
    logic clear;
    logic pop;
    logic push;
    logic merge;
  } fra_q_cmd_t;

endpackage

@@ sv/fenced_ring_allocator.sv @@
// Top level of the fenced ring allocator: control, ring arithmetic and output register.
// Begin frame and no operation pass through EXEC and FINISH; allocate through EXEC, SIZE,
// COMMIT, FINISH; end frame through EXEC, RETIRE and FINISH, retiring one entry per cycle
// as the queue cells shift toward the front. One item is in work at a time; the next
// transfer is taken in the cycle after the result is loaded into the output register.
// Synchronous reset sets ring_size 65536, align_log2 8, fence 0 and an empty queue.
module fenced_ring_allocator #(
  parameter int QUEUE_DEPTH = 8,
  parameter int FENCE_BITS = 48
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [fra_pkg::KIND_W-1:0]     kind,
  input  logic [fra_pkg::UNIT_W-1:0]     request_size,
  input  logic [FENCE_BITS-1:0]          completed_fence,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fra_pkg::STATUS_W-1:0]   status,
  output logic [fra_pkg::OFFSET_W-1:0]   alloc_offset,
  output logic [fra_pkg::UNIT_W-1:0]     free_units,
  output logic [FENCE_BITS-1:0]          frame_fence,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fra_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int U = fra_pkg::UNIT_W;

  fra_pkg::fra_state_t state, state_next;

  logic [U-1:0]                  ring_size;
  logic [fra_pkg::ALIGN_W-1:0]   align_log2;
  logic [U-1:0]                  free_capacity;
  logic [fra_pkg::OFFSET_W-1:0]  head_offset;
  logic [FENCE_BITS-1:0]         frame_counter;

  logic [fra_pkg::KIND_W-1:0]    kind_w;
  logic [U-1:0]                  req_w;
  logic [FENCE_BITS-1:0]         done_w;
  logic [U-1:0]                  start_r;
  logic [U:0]                    total_r;
  logic [U:0]                    head_sum;
  logic                          room_bad;
  logic [fra_pkg::STATUS_W-1:0]  status_r;
  logic [fra_pkg::OFFSET_W-1:0]  offset_r;

  fra_pkg::fra_q_cmd_t           q_cmd;
  logic [CNT_W-1:0]              q_count;
  logic [FENCE_BITS-1:0]         q_front_fence;
  logic [U-1:0]                  q_front_units;
  logic [FENCE_BITS-1:0]         q_newest_fence;

  logic                          cfg_fire;
  logic                          in_fire;
  logic                          out_load;
  logic [U-1:0]                  amask;
  logic [U-1:0]                  left;
  logic                          wrap;
  logic [U-1:0]                  pad;
  logic                          need_push;
  logic                          queue_full;
  logic                          commit_ok;
  logic                          retire_hit;
  logic [U:0]                    head_wrapped;

  assign cfg_ready = !rst && (state == fra_pkg::ST_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && !in_stall;
  assign out_load  = (state == fra_pkg::ST_FINISH) && (!out_valid || !out_stall);

  assign amask = (U'(1) << align_log2) - U'(1);
  assign left  = ring_size - start_r;
  assign wrap  = req_w > left;
  assign pad   = wrap ? (ring_size - U'(head_offset)) : (start_r - U'(head_offset));

  assign need_push  = (q_count == '0) || (q_newest_fence < frame_counter);
  assign queue_full = q_count >= CNT_W'(QUEUE_DEPTH);
  assign commit_ok  = !room_bad && !(total_r > {1'b0, free_capacity}) &&
                      !(need_push && queue_full);
  assign retire_hit = (q_count != '0) && (q_front_fence < done_w);
  assign head_wrapped = (head_sum >= {1'b0, ring_size}) ? head_sum - {1'b0, ring_size}
                                                        : head_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fra_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fra_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = fra_pkg::ST_EXEC;
        end
      end
      fra_pkg::ST_EXEC: begin
        case (kind_w)
          fra_pkg::KIND_END:   state_next = fra_pkg::ST_RETIRE;
          fra_pkg::KIND_ALLOC: state_next = fra_pkg::ST_SIZE;
          default:             state_next = fra_pkg::ST_FINISH;
        endcase
      end
      fra_pkg::ST_SIZE:   state_next = fra_pkg::ST_COMMIT;
      fra_pkg::ST_COMMIT: state_next = fra_pkg::ST_FINISH;
      fra_pkg::ST_RETIRE: begin
        if (!retire_hit) begin
          state_next = fra_pkg::ST_FINISH;
        end
      end
      fra_pkg::ST_FINISH: begin
        if (out_load) begin
          state_next = fra_pkg::ST_IDLE;
        end
      end
      default: state_next = fra_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    q_cmd.clear = cfg_fire && (cfg_index == fra_pkg::CFG_RING_SIZE);
    q_cmd.pop   = 1'b0;
    q_cmd.push  = 1'b0;
    q_cmd.merge = 1'b0;
    case (state)
      fra_pkg::ST_IDLE: in_stall = rst;
      fra_pkg::ST_COMMIT: begin
        q_cmd.push  = commit_ok && need_push;
        q_cmd.merge = commit_ok && !need_push;
      end
      fra_pkg::ST_RETIRE: q_cmd.pop = retire_hit;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size     <= fra_pkg::RING_RESET;
      align_log2    <= fra_pkg::ALIGN_RESET;
      free_capacity <= fra_pkg::RING_RESET;
      head_offset   <= '0;
      frame_counter <= '0;
    end else if (cfg_fire) begin
      case (cfg_index)
        fra_pkg::CFG_RING_SIZE: begin
          ring_size     <= (cfg_data > fra_pkg::RING_MAX) ? fra_pkg::RING_MAX : cfg_data;
          free_capacity <= (cfg_data > fra_pkg::RING_MAX) ? fra_pkg::RING_MAX : cfg_data;
          head_offset   <= '0;
        end
        fra_pkg::CFG_ALIGN_LOG2: align_log2 <= cfg_data[fra_pkg::ALIGN_W-1:0];
        default: align_log2 <= align_log2;
      endcase
    end else begin
      case (state)
        fra_pkg::ST_EXEC: begin
          if (kind_w == fra_pkg::KIND_BEGIN) begin
            frame_counter <= frame_counter + FENCE_BITS'(1);
          end
        end
        fra_pkg::ST_COMMIT: begin
          if (commit_ok) begin
            free_capacity <= free_capacity - total_r[U-1:0];
            head_offset   <= head_wrapped[fra_pkg::OFFSET_W-1:0];
          end
        end
        fra_pkg::ST_RETIRE: begin
          if (retire_hit) begin
            free_capacity <= free_capacity + q_front_units;
            if (q_count == CNT_W'(1)) begin
              head_offset <= '0;
            end
          end
        end
        default: head_offset <= head_offset;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_w <= kind;
      req_w  <= request_size;
      done_w <= completed_fence;
    end
    case (state)
      fra_pkg::ST_EXEC: begin
        start_r  <= (U'(head_offset) + amask) & ~amask;
        status_r <= fra_pkg::STATUS_OK;
        offset_r <= '0;
      end
      fra_pkg::ST_SIZE: begin
        room_bad <= (free_capacity == '0) || (start_r >= ring_size);
        total_r  <= {1'b0, req_w} + {1'b0, pad};
        head_sum <= wrap ? ({1'b0, ring_size} + {1'b0, req_w})
                         : ({1'b0, start_r} + {1'b0, req_w});
        start_r  <= wrap ? '0 : start_r;
      end
      fra_pkg::ST_COMMIT: begin
        if (commit_ok) begin
          offset_r <= start_r[fra_pkg::OFFSET_W-1:0];
        end else if (room_bad || total_r > {1'b0, free_capacity}) begin
          status_r <= fra_pkg::STATUS_NO_ROOM;
        end else begin
          status_r <= fra_pkg::STATUS_QUEUE_FULL;
        end
      end
      default: start_r <= start_r;
    endcase
  end

  fra_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .FENCE_BITS(FENCE_BITS),
    .CNT_W(CNT_W)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .cmd(q_cmd),
    .push_fence(frame_counter),
    .add_units(total_r[U-1:0]),
    .count(q_count),
    .front_fence(q_front_fence),
    .front_units(q_front_units),
    .newest_fence(q_newest_fence)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= status_r;
      alloc_offset <= offset_r;
      free_units   <= free_capacity;
      frame_fence  <= frame_counter;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("pending queue count above its depth");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_capacity <= ring_size)
    else $error("free capacity above ring size");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    (U'(head_offset) < ring_size) || (head_offset == '0))
    else $error("head offset outside the ring");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == fra_pkg::ST_EXEC))
    else $error("accepted transfer did not start execution");

endmodule

@@ sv/fra_cell.sv @@
// One cell of the pending queue chain: holds the fence and unit count of one entry.
module fra_cell #(
  parameter int FENCE_BITS = 48,
  parameter int CNT_W = 4,
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  fra_pkg::fra_q_cmd_t       cmd,
  input  logic [CNT_W-1:0]          count,
  input  logic [FENCE_BITS-1:0]     push_fence,
  input  logic [fra_pkg::UNIT_W-1:0] add_units,
  input  logic [FENCE_BITS-1:0]     next_fence,
  input  logic [fra_pkg::UNIT_W-1:0] next_units,
  output logic [FENCE_BITS-1:0]     fence,
  output logic [fra_pkg::UNIT_W-1:0] units
);

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      fence <= next_fence;
      units <= next_units;
    end else if (cmd.push && count == CNT_W'(INDEX)) begin
      fence <= push_fence;
      units <= add_units;
    end else if (cmd.merge && count == CNT_W'(INDEX + 1)) begin
      units <= units + add_units;
    end
  end

endmodule

@@ sv/fra_queue.sv @@
// Pending queue built as a row of cells that shift toward the front on retirement.
module fra_queue #(
  parameter int QUEUE_DEPTH = 8,
  parameter int FENCE_BITS = 48,
  parameter int CNT_W = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  fra_pkg::fra_q_cmd_t        cmd,
  input  logic [FENCE_BITS-1:0]      push_fence,
  input  logic [fra_pkg::UNIT_W-1:0] add_units,
  output logic [CNT_W-1:0]           count,
  output logic [FENCE_BITS-1:0]      front_fence,
  output logic [fra_pkg::UNIT_W-1:0] front_units,
  output logic [FENCE_BITS-1:0]      newest_fence
);

  logic [FENCE_BITS-1:0]      fence_row [QUEUE_DEPTH];
  logic [fra_pkg::UNIT_W-1:0] units_row [QUEUE_DEPTH];
  logic [FENCE_BITS-1:0]      fence_in  [QUEUE_DEPTH];
  logic [fra_pkg::UNIT_W-1:0] units_in  [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign fence_in[i] = '0;
      assign units_in[i] = '0;
    end else begin : g_mid
      assign fence_in[i] = fence_row[i+1];
      assign units_in[i] = units_row[i+1];
    end

    fra_cell #(
      .FENCE_BITS(FENCE_BITS),
      .CNT_W(CNT_W),
      .INDEX(i)
    ) u_cell (
      .clk(clk),
      .cmd(cmd),
      .count(count),
      .push_fence(push_fence),
      .add_units(add_units),
      .next_fence(fence_in[i]),
      .next_units(units_in[i]),
      .fence(fence_row[i]),
      .units(units_row[i])
    );
  end

  assign front_fence = fence_row[0];
  assign front_units = units_row[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.pop) begin
      count <= count - CNT_W'(1);
    end else if (cmd.push) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      newest_fence <= push_fence;
    end
  end

endmodule
